// ----- sv/mxq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxq_pkg: shared types and constants for the min-extract queue
// Sizes, request and status codes, sequencer states and the control
// structs that pass between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package mxq_pkg;

  localparam int unsigned DEPTH      = 128;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic {
    REQ_ADD     = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WBACK
  } state_e;

  // One read issued by the sequencer during a scan
  typedef struct packed {
    logic  vld;
    logic  first;
    logic  last;
    addr_t idx;
  } scan_ctl_t;

  // What the compare unit has found so far
  typedef struct packed {
    data_t best_val;
    addr_t best_idx;
    data_t last_val;
  } scan_res_t;

endpackage

// ----- sv/min_extract_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_extract_queue: linear-scan priority queue of signed values
// Unsorted store with fill count; add appends, extract scans for the
// smallest entry and backfills its slot with the last entry.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add requests and
// refused requests (add when full, extract when empty) return their result
// in the cycle after acceptance and never raise busy. An extract on a
// store of n entries reads every entry through the single memory read
// port, one per cycle, into one shared comparator; the result strobe
// res_valid_o follows the scan, a drain state and a write-back state,
// and busy is high until then. Each result is presented for one cycle
// only and the receiver cannot stall it.
module min_extract_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic signed [31:0] value_i,
  output logic        res_valid_o,
  output logic signed [31:0] min_value_o,
  output logic [1:0]  status_o,
  output logic        now_empty_o,
  output logic [7:0]  fill_count_o
);

  mxq_pkg::scan_ctl_t ctl;
  mxq_pkg::scan_res_t scan_res;
  mxq_pkg::status_e   status;
  mxq_pkg::cnt_t      cnt;
  mxq_pkg::data_t     min_value;
  logic               wr_en;
  mxq_pkg::addr_t     wr_addr;
  mxq_pkg::data_t     wr_data;
  logic               rd_en;
  mxq_pkg::addr_t     rd_addr;
  mxq_pkg::data_t     rd_data;

  mxq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .res_valid_o (res_valid_o),
    .min_value_o (min_value),
    .status_o    (status),
    .cnt_o       (cnt),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .ctl_o       (ctl),
    .res_i       (scan_res)
  );

  mxq_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mxq_cmp u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_i (rd_data),
    .res_o     (scan_res)
  );

  // result fields
  assign min_value_o  = min_value;
  assign status_o     = status;
  assign now_empty_o  = (cnt == '0);
  assign fill_count_o = 8'(cnt);

endmodule

// ----- sv/mxq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxq_store: entry memory
// One write port and one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module mxq_store (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  mxq_pkg::addr_t     wr_addr_i,
  input  mxq_pkg::data_t     wr_data_i,
  input  logic               rd_en_i,
  input  mxq_pkg::addr_t     rd_addr_i,
  output mxq_pkg::data_t     rd_data_o
);

  mxq_pkg::data_t mem_q [mxq_pkg::DEPTH];
  mxq_pkg::data_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/mxq_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxq_cmp: shared signed comparator for the minimum scan
// Compares each entry read back from the store against the running
// minimum; strict less-than keeps the lowest position on ties.
// ----------------------------------------------------------------------------
module mxq_cmp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mxq_pkg::scan_ctl_t   ctl_i,
  input  mxq_pkg::data_t       rd_data_i,
  output mxq_pkg::scan_res_t   res_o
);

  mxq_pkg::scan_ctl_t ctl_q;
  mxq_pkg::data_t     best_val_q;
  mxq_pkg::addr_t     best_idx_q;
  mxq_pkg::data_t     last_val_q;
  logic               take_new;

  // align control with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  assign take_new = ctl_q.vld && (ctl_q.first || (rd_data_i < best_val_q));

  // running minimum and last entry capture
  always_ff @(posedge clk_i) begin
    if (take_new) begin
      best_val_q <= rd_data_i;
      best_idx_q <= ctl_q.idx;
    end
    if (ctl_q.vld && ctl_q.last) begin
      last_val_q <= rd_data_i;
    end
  end

  assign res_o.best_val = best_val_q;
  assign res_o.best_idx = best_idx_q;
  assign res_o.last_val = last_val_q;

endmodule

// ----- sv/mxq_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxq_seq: request sequencer
// Holds the fill count, handles add requests and refusals at once, and
// walks the store one read per cycle for an extract, then writes the last
// entry into the vacated slot.
// ----------------------------------------------------------------------------
module mxq_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  mxq_pkg::data_t       value_i,
  output logic                 res_valid_o,
  output mxq_pkg::data_t       min_value_o,
  output mxq_pkg::status_e     status_o,
  output mxq_pkg::cnt_t        cnt_o,
  output logic                 wr_en_o,
  output mxq_pkg::addr_t       wr_addr_o,
  output mxq_pkg::data_t       wr_data_o,
  output logic                 rd_en_o,
  output mxq_pkg::addr_t       rd_addr_o,
  output mxq_pkg::scan_ctl_t   ctl_o,
  input  mxq_pkg::scan_res_t   res_i
);

  mxq_pkg::state_e   state_q, state_d;
  mxq_pkg::cnt_t     cnt_q;
  mxq_pkg::addr_t    rd_idx_q;
  logic              res_valid_q;
  mxq_pkg::data_t    min_q;
  mxq_pkg::status_e  status_q;

  logic              accept;
  logic              is_extract;
  logic              is_full;
  logic              is_empty;
  mxq_pkg::addr_t    last_idx;
  logic              add_ok;

  assign is_extract = (mxq_pkg::req_e'(req_type_i) == mxq_pkg::REQ_EXTRACT);
  assign is_full    = (cnt_q == mxq_pkg::CNT_W'(mxq_pkg::DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign last_idx   = mxq_pkg::ADDR_W'(cnt_q - mxq_pkg::CNT_W'(1));
  assign accept     = start && (state_q == mxq_pkg::S_IDLE);
  assign add_ok     = accept && !is_extract && !is_full;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mxq_pkg::S_IDLE: begin
        if (accept && is_extract && !is_empty) begin
          state_d = mxq_pkg::S_SCAN;
        end
      end
      mxq_pkg::S_SCAN: begin
        if (rd_idx_q == last_idx) begin
          state_d = mxq_pkg::S_DRAIN;
        end
      end
      mxq_pkg::S_DRAIN: state_d = mxq_pkg::S_WBACK;
      mxq_pkg::S_WBACK: state_d = mxq_pkg::S_IDLE;
      default:          state_d = mxq_pkg::S_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    busy      = 1'b1;
    rd_en_o   = 1'b0;
    ctl_o     = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = cnt_q[mxq_pkg::ADDR_W-1:0];
    wr_data_o = value_i;
    case (state_q)
      mxq_pkg::S_IDLE: begin
        busy    = 1'b0;
        wr_en_o = add_ok;
      end
      mxq_pkg::S_SCAN: begin
        rd_en_o     = 1'b1;
        ctl_o.vld   = 1'b1;
        ctl_o.first = (rd_idx_q == '0);
        ctl_o.last  = (rd_idx_q == last_idx);
        ctl_o.idx   = rd_idx_q;
      end
      mxq_pkg::S_DRAIN: begin
      end
      mxq_pkg::S_WBACK: begin
        wr_en_o   = 1'b1;
        wr_addr_o = res_i.best_idx;
        wr_data_o = res_i.last_val;
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_o = rd_idx_q;

  // control state: fsm, fill count, scan index, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mxq_pkg::S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (accept) begin
        rd_idx_q <= '0;
        if (!(is_extract && !is_empty)) begin
          res_valid_q <= 1'b1;
        end
      end
      if (add_ok) begin
        cnt_q <= cnt_q + mxq_pkg::CNT_W'(1);
      end
      if (state_q == mxq_pkg::S_SCAN) begin
        rd_idx_q <= rd_idx_q + mxq_pkg::ADDR_W'(1);
      end
      if (state_q == mxq_pkg::S_WBACK) begin
        cnt_q       <= cnt_q - mxq_pkg::CNT_W'(1);
        res_valid_q <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q <= '0;
      if (is_extract) begin
        status_q <= is_empty ? mxq_pkg::STAT_EMPTY : mxq_pkg::STAT_OK;
      end else begin
        status_q <= is_full ? mxq_pkg::STAT_FULL : mxq_pkg::STAT_OK;
      end
    end
    if (state_q == mxq_pkg::S_WBACK) begin
      min_q    <= res_i.best_val;
      status_q <= mxq_pkg::STAT_OK;
    end
  end

  assign res_valid_o = res_valid_q;
  assign min_value_o = min_q;
  assign status_o    = status_q;
  assign cnt_o       = cnt_q;

  // fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mxq_pkg::CNT_W'(mxq_pkg::DEPTH))
    else $error("fill count above depth");

  // scan reads stay inside the held entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxq_pkg::S_SCAN) |-> (mxq_pkg::CNT_W'(rd_idx_q) < cnt_q))
    else $error("scan read beyond fill count");

  // write-back slot is a held entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxq_pkg::S_WBACK) |-> (mxq_pkg::CNT_W'(res_i.best_idx) < cnt_q))
    else $error("write-back slot beyond fill count");

  // a finished extract drops the count by one and strobes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxq_pkg::S_WBACK) |=>
      (res_valid_q && (cnt_q == $past(cnt_q) - mxq_pkg::CNT_W'(1))))
    else $error("extract completion mismatch");

endmodule
